// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off during reset
`define PWVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every rising edge, also during reset
`define PWVM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pwvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pwvm_pkg
// Types, codes and sizes shared by the wavetable voice mixer.
// ----------------------------------------------------------------------------
package pwvm_pkg;

    localparam int VOICES_DEF     = 16;
    localparam int WAVE_DEPTH_DEF = 4096;
    localparam int ENV_DEPTH_DEF  = 256;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_ENV   = 3'd1;
    localparam logic [2:0] REQ_NOTE  = 3'd2;
    localparam logic [2:0] REQ_WAVEW = 3'd3;
    localparam logic [2:0] REQ_INCW  = 3'd4;
    localparam logic [2:0] REQ_ENVW  = 3'd5;

    localparam logic [1:0] CFG_WAVE_LEN   = 2'd0;
    localparam logic [1:0] CFG_LOOP_LEN   = 2'd1;
    localparam logic [1:0] CFG_ATTACK_LEN = 2'd2;
    localparam logic [1:0] CFG_ENV_LEN    = 2'd3;

    localparam logic [7:0] LEVEL_FULL = 8'hff;

    typedef enum logic [2:0] {
        K_TICK,
        K_ENV,
        K_NOTE,
        K_WAVEW,
        K_INCW,
        K_ENVW
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [6:0]         note;
        logic [11:0]        tidx;
        logic signed [15:0] sample;
        logic [19:0]        incr;
        logic [7:0]         env;
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_MUL,
        ST_TICK_SCALE,
        ST_TICK_ACC,
        ST_EMIT,
        ST_ENV_RD,
        ST_ENV_WR,
        ST_NOTE_RD,
        ST_NOTE_WR
    } t_state;

endpackage

// ===== rtl/polyphonic_wavetable_voice_mixer_top.sv =====
// A sample tick visits each voice with one shared interpolate and scale unit;
// an active voice passes through it in order (wave memory read, fraction
// multiply, level multiply, accumulate). An envelope tick walks every voice.
// Requests queue in a two-entry buffer so the input side keeps moving while
// the engine works, and a finished mix waits in an output register. Wave and
// envelope depths are expected to be powers of two.
// ----------------------------------------------------------------------------
// polyphonic_wavetable_voice_mixer_top
// Wavetable voice engine: request front end, queue and voice engine.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_voice_mixer_top
    import pwvm_pkg::*;
#(
    parameter int VOICES     = VOICES_DEF,
    parameter int WAVE_DEPTH = WAVE_DEPTH_DEF,
    parameter int ENV_DEPTH  = ENV_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_req_type,
    input  logic [6:0]         i_note,
    input  logic [11:0]        i_table_index,
    input  logic signed [15:0] i_wave_sample,
    input  logic [19:0]        i_increment_value,
    input  logic [7:0]         i_envelope_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_mix_out
);

    logic q_valid;
    logic q_pop;
    t_req q_req;

    assign o_cfg_ready = 1'b1;

    pwvm_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_note            (i_note),
        .i_table_index     (i_table_index),
        .i_wave_sample     (i_wave_sample),
        .i_increment_value (i_increment_value),
        .i_envelope_value  (i_envelope_value),
        .o_q_valid         (q_valid),
        .o_q_req           (q_req),
        .i_q_pop           (q_pop)
    );

    pwvm_engine #(
        .VOICES     (VOICES),
        .WAVE_DEPTH (WAVE_DEPTH),
        .ENV_DEPTH  (ENV_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_mix_out   (o_mix_out)
    );

endmodule

// ===== rtl/pwvm_front.sv =====
// ----------------------------------------------------------------------------
// pwvm_front
// Accepts requests, decodes the kind, drops unknown kinds and queues the rest.
// ----------------------------------------------------------------------------
module pwvm_front
    import pwvm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_req_type,
    input  logic [6:0]         i_note,
    input  logic [11:0]        i_table_index,
    input  logic signed [15:0] i_wave_sample,
    input  logic [19:0]        i_increment_value,
    input  logic [7:0]         i_envelope_value,
    output logic               o_q_valid,
    output t_req               o_q_req,
    input  logic               i_q_pop
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_req           r_q [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QCW-1:0] r_count, n_count;
    t_kind          c_kind;
    logic           c_known;
    logic           c_push;
    t_req           c_req;

    always_comb begin
        c_kind  = K_TICK;
        c_known = 1'b1;
        case (i_req_type)
            REQ_TICK:  c_kind = K_TICK;
            REQ_ENV:   c_kind = K_ENV;
            REQ_NOTE:  c_kind = K_NOTE;
            REQ_WAVEW: c_kind = K_WAVEW;
            REQ_INCW:  c_kind = K_INCW;
            REQ_ENVW:  c_kind = K_ENVW;
            default:   c_known = 1'b0;
        endcase
    end

    assign o_stall = (r_count == QCW'(QUEUE_DEPTH));
    assign c_push  = i_valid && !o_stall && c_known;

    always_comb begin
        c_req.kind   = c_kind;
        c_req.note   = i_note;
        c_req.tidx   = i_table_index;
        c_req.sample = i_wave_sample;
        c_req.incr   = i_increment_value;
        c_req.env    = i_envelope_value;
    end

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (c_push) begin
            n_wr = (r_wr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd = (r_rd == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (c_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!c_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wr] <= c_req;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_req   = r_q[r_rd];

endmodule

// ===== rtl/pwvm_engine.sv =====
// ----------------------------------------------------------------------------
// pwvm_engine
// Executes queued requests: voice walk for sample and envelope ticks, note on, table loads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwvm_engine
    import pwvm_pkg::*;
#(
    parameter int VOICES     = VOICES_DEF,
    parameter int WAVE_DEPTH = WAVE_DEPTH_DEF,
    parameter int ENV_DEPTH  = ENV_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_req               i_q_req,
    output logic               o_q_pop,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_mix_out
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(WAVE_DEPTH);
    localparam int EW = $clog2(ENV_DEPTH);

    t_state r_state, n_state;

    logic [11:0] r_wave_len, r_loop_len, r_attack_len;
    logic [8:0]  r_env_len;

    logic [19:0] r_vinc   [VOICES];
    logic [20:0] r_vphase [VOICES];
    logic [7:0]  r_vlevel [VOICES];
    logic [7:0]  r_veidx  [VOICES];
    logic [VW-1:0] r_next_voice;
    logic [VW-1:0] r_vc;

    logic signed [15:0] r_wave [WAVE_DEPTH];
    logic [19:0]        r_inc_tab [128];
    logic [7:0]         r_env_tab [ENV_DEPTH];

    t_req               r_req;
    logic signed [15:0] r_s1, r_s2;
    logic [7:0]         r_f;
    logic signed [25:0] r_prod;
    logic signed [24:0] r_scaled;
    logic [31:0]        r_mix;
    logic [19:0]        r_inc_rd;
    logic [7:0]         r_env_rd;
    logic               r_o_valid;
    logic [31:0]        r_o_mix;
    logic               r_pend_w;

    logic        c_pop, c_last, c_active, c_env_go, c_load_out;
    logic [20:0] c_phase;
    logic [7:0]  c_eidx;
    logic [21:0] c_sum;
    logic [20:0] c_new_phase;
    logic [31:0] c_ph_ext, c_wr_ext, c_ew_ext, c_er_ext;
    logic [AW-1:0] c_rd_i, c_rd_j, c_wr_i;
    logic [EW-1:0] c_ew_i, c_er_i;
    logic [8:0]  c_lim;
    logic signed [16:0] c_diff;
    logic signed [17:0] c_interp;

    // per-voice reads at the walk counter
    always_comb begin
        c_phase  = r_vphase[r_vc];
        c_eidx   = r_veidx[r_vc];
        c_active = (r_vlevel[r_vc] != '0);
        c_last   = (r_vc == VW'(VOICES - 1));
        c_ph_ext = 32'(c_phase[20:8]);
        c_rd_i   = c_ph_ext[AW-1:0];
        c_rd_j   = c_rd_i + 1'b1;
        c_wr_ext = 32'(r_req.tidx);
        c_wr_i   = c_wr_ext[AW-1:0];
        c_ew_ext = 32'(r_req.tidx);
        c_ew_i   = c_ew_ext[EW-1:0];
        c_er_ext = 32'(c_eidx);
        c_er_i   = c_er_ext[EW-1:0];
        c_lim    = (32'(r_env_len) < ENV_DEPTH) ? r_env_len : 9'(ENV_DEPTH);
        c_env_go = (c_phase[20:8] >= {1'b0, r_attack_len})
                   && (({1'b0, c_eidx} + 9'd1) < c_lim);
        c_sum    = {1'b0, c_phase} + {2'b00, r_vinc[r_vc]};
        // wrap back by the loop length once the wave end is reached
        if (c_sum >= {2'b00, r_wave_len, 8'h00}) begin
            c_sum = c_sum - {2'b00, r_loop_len, 8'h00};
        end
        c_new_phase = c_sum[20:0];
        c_diff   = $signed({r_s2[15], r_s2}) - $signed({r_s1[15], r_s1});
        // arithmetic shift gives the floor of the fraction product
        c_interp = $signed({{2{r_s1[15]}}, r_s1}) + $signed(r_prod[25:8]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_req.kind)
                        K_TICK:  n_state = ST_TICK_RD;
                        K_ENV:   n_state = ST_ENV_RD;
                        K_NOTE:  n_state = ST_NOTE_RD;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_RD: begin
                if (c_active) begin
                    n_state = ST_TICK_MUL;
                end else if (c_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_TICK_MUL:   n_state = ST_TICK_SCALE;
            ST_TICK_SCALE: n_state = ST_TICK_ACC;
            ST_TICK_ACC:   n_state = c_last ? ST_EMIT : ST_TICK_RD;
            ST_EMIT: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ENV_RD: begin
                if (c_env_go) begin
                    n_state = ST_ENV_WR;
                end else if (c_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ENV_WR:  n_state = c_last ? ST_IDLE : ST_ENV_RD;
            ST_NOTE_RD: n_state = ST_NOTE_WR;
            ST_NOTE_WR: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        c_pop      = 1'b0;
        c_load_out = 1'b0;
        case (r_state)
            ST_IDLE: c_pop      = i_q_valid;
            ST_EMIT: c_load_out = !r_o_valid || !i_stall;
            default: begin
                c_pop      = 1'b0;
                c_load_out = 1'b0;
            end
        endcase
    end

    assign o_q_pop = c_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_len   <= 12'd4095;
            r_loop_len   <= 12'd4095;
            r_attack_len <= 12'd0;
            r_env_len    <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WAVE_LEN:   r_wave_len   <= i_cfg_data;
                CFG_LOOP_LEN:   r_loop_len   <= i_cfg_data;
                CFG_ATTACK_LEN: r_attack_len <= i_cfg_data;
                CFG_ENV_LEN:    r_env_len    <= i_cfg_data[8:0];
                default:        r_env_len    <= r_env_len;
            endcase
        end
    end

    // voice state and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_vinc[v]   <= '0;
                r_vphase[v] <= '0;
                r_vlevel[v] <= '0;
                r_veidx[v]  <= '0;
            end
            r_next_voice <= '0;
            r_vc         <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (c_load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: r_vc <= '0;
                ST_TICK_RD: begin
                    if (c_active) begin
                        r_vphase[r_vc] <= c_new_phase;
                    end else if (!c_last) begin
                        r_vc <= r_vc + 1'b1;
                    end
                end
                ST_TICK_ACC: begin
                    if (!c_last) begin
                        r_vc <= r_vc + 1'b1;
                    end
                end
                ST_ENV_RD: begin
                    if (!c_env_go && !c_last) begin
                        r_vc <= r_vc + 1'b1;
                    end
                end
                ST_ENV_WR: begin
                    r_vlevel[r_vc] <= r_env_rd;
                    r_veidx[r_vc]  <= c_eidx + 8'd1;
                    if (!c_last) begin
                        r_vc <= r_vc + 1'b1;
                    end
                end
                ST_NOTE_WR: begin
                    r_vinc[r_next_voice]   <= r_inc_rd;
                    r_vphase[r_next_voice] <= '0;
                    r_vlevel[r_next_voice] <= LEVEL_FULL;
                    r_veidx[r_next_voice]  <= '0;
                    r_next_voice <= (r_next_voice == VW'(VOICES - 1)) ? '0
                                    : r_next_voice + 1'b1;
                end
                default: r_vc <= r_vc;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (c_pop) begin
            r_req <= i_q_req;
        end
        case (r_state)
            ST_IDLE:       r_mix    <= '0;
            ST_TICK_RD:    r_f      <= c_phase[7:0];
            ST_TICK_MUL:   r_prod   <= c_diff * $signed({1'b0, r_f});
            ST_TICK_SCALE: r_scaled <= $signed({1'b0, r_vlevel[r_vc]}) * $signed(c_interp[15:0]);
            ST_TICK_ACC:   r_mix    <= r_mix + {{7{r_scaled[24]}}, r_scaled};
            default:       r_mix    <= r_mix;
        endcase
        if (c_load_out) begin
            r_o_mix <= r_mix;
        end
    end

    // wave memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && r_req.kind == K_WAVEW && r_pend_w) begin
            r_wave[c_wr_i] <= r_req.sample;
        end
        if (r_state == ST_TICK_RD) begin
            r_s1 <= r_wave[c_rd_i];
            r_s2 <= r_wave[c_rd_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && r_req.kind == K_INCW && r_pend_w) begin
            r_inc_tab[r_req.tidx[6:0]] <= r_req.incr;
        end
        if (r_state == ST_NOTE_RD) begin
            r_inc_rd <= r_inc_tab[r_req.note];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && r_req.kind == K_ENVW && r_pend_w) begin
            r_env_tab[c_ew_i] <= r_req.env;
        end
        if (r_state == ST_ENV_RD) begin
            r_env_rd <= r_env_tab[c_er_i];
        end
    end

    // a table load popped last cycle is written on the following idle cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_w <= 1'b0;
        end else begin
            r_pend_w <= c_pop && (i_q_req.kind == K_WAVEW || i_q_req.kind == K_INCW
                                  || i_q_req.kind == K_ENVW);
        end
    end

    assign o_valid   = r_o_valid;
    assign o_mix_out = r_o_mix;

    `PWVM_ASSERT(a_vc_range, (r_state != ST_IDLE) |-> (32'(r_vc) < VOICES), "walk counter out of range")
    `PWVM_ASSERT(a_load_from_emit, $rose(r_o_valid) |-> ($past(r_state) == ST_EMIT), "result not from emit")
    `PWVM_ASSERT(a_emit_loads, (r_state == ST_EMIT && !r_o_valid) |=> r_o_valid, "emit did not load result")
    `PWVM_ASSERT(a_pop_idle, o_q_pop |-> (r_state == ST_IDLE && i_q_valid), "pop outside idle")

endmodule
